[design/tapp_pkg.sv]
package tapp_pkg;

	localparam int INTEGRAL_WIDTH = 48;
	localparam int AXIS_COUNT = 3;
	localparam int SUM_MAG_W = 64;
	localparam int ACC_W = 128;
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_HEADING = 2;

	localparam logic [31:0] AXIS_FACTOR [AXIS_COUNT] = '{32'd1, 32'd1, 32'd411775};
	localparam int AXIS_SHIFT [AXIS_COUNT] = '{40, 40, 56};

	localparam logic [REG_IDX_W-1:0] REG_KP = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KI = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KD = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MASS_SURGE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MASS_SWAY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INERTIA_YAW = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FORCE_LIMIT = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MOMENT_LIMIT = 3'd7;

	localparam logic [31:0] KP_RESET = 32'd16777;
	localparam logic [31:0] KI_RESET = 32'd0;
	localparam logic [31:0] KD_RESET = 32'd0;
	localparam logic [31:0] MASS_SURGE_RESET = 32'd5312200;
	localparam logic [31:0] MASS_SWAY_RESET = 32'd8283100;
	localparam logic [31:0] INERTIA_YAW_RESET = 32'd3745400000;
	localparam logic [30:0] FORCE_LIMIT_RESET = 31'd1600000;
	localparam logic [30:0] MOMENT_LIMIT_RESET = 31'd60000000;

	typedef struct packed {
		logic signed [31:0] meas_x;
		logic signed [31:0] meas_y;
		logic [15:0] meas_heading;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic [15:0] target_heading;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] force_surge;
		logic signed [31:0] force_sway;
		logic signed [31:0] moment_yaw;
	} force_t;

	typedef struct packed {
		logic [31:0] kp_gain;
		logic [31:0] ki_gain;
		logic [31:0] kd_gain;
		logic [31:0] mass_surge;
		logic [31:0] mass_sway;
		logic [31:0] inertia_yaw;
		logic [30:0] force_limit;
		logic [30:0] moment_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0] e_mag;
		logic e_neg;
		logic [SUM_MAG_W-1:0] s_mag;
		logic s_neg;
		logic [31:0] d_mag;
		logic d_neg;
	} lane_op_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[design/tapp_regs.sv]
module tapp_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tapp_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output tapp_pkg::cfg_t cfg
);

	tapp_pkg::cfg_t cfg_q;
	logic [tapp_pkg::REG_IDX_W-1:0] idx;
	logic wr;

	assign idx = paddr[tapp_pkg::ADDR_W-1:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain <= tapp_pkg::KP_RESET;
			cfg_q.ki_gain <= tapp_pkg::KI_RESET;
			cfg_q.kd_gain <= tapp_pkg::KD_RESET;
			cfg_q.mass_surge <= tapp_pkg::MASS_SURGE_RESET;
			cfg_q.mass_sway <= tapp_pkg::MASS_SWAY_RESET;
			cfg_q.inertia_yaw <= tapp_pkg::INERTIA_YAW_RESET;
			cfg_q.force_limit <= tapp_pkg::FORCE_LIMIT_RESET;
			cfg_q.moment_limit <= tapp_pkg::MOMENT_LIMIT_RESET;
		end else if (wr) begin
			case (idx)
				tapp_pkg::REG_KP: cfg_q.kp_gain <= pwdata;
				tapp_pkg::REG_KI: cfg_q.ki_gain <= pwdata;
				tapp_pkg::REG_KD: cfg_q.kd_gain <= pwdata;
				tapp_pkg::REG_MASS_SURGE: cfg_q.mass_surge <= pwdata;
				tapp_pkg::REG_MASS_SWAY: cfg_q.mass_sway <= pwdata;
				tapp_pkg::REG_INERTIA_YAW: cfg_q.inertia_yaw <= pwdata;
				tapp_pkg::REG_FORCE_LIMIT: cfg_q.force_limit <= pwdata[30:0];
				tapp_pkg::REG_MOMENT_LIMIT: cfg_q.moment_limit <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tapp_pkg::REG_KP: prdata = cfg_q.kp_gain;
			tapp_pkg::REG_KI: prdata = cfg_q.ki_gain;
			tapp_pkg::REG_KD: prdata = cfg_q.kd_gain;
			tapp_pkg::REG_MASS_SURGE: prdata = cfg_q.mass_surge;
			tapp_pkg::REG_MASS_SWAY: prdata = cfg_q.mass_sway;
			tapp_pkg::REG_INERTIA_YAW: prdata = cfg_q.inertia_yaw;
			tapp_pkg::REG_FORCE_LIMIT: prdata = {1'b0, cfg_q.force_limit};
			tapp_pkg::REG_MOMENT_LIMIT: prdata = {1'b0, cfg_q.moment_limit};
			default: prdata = '0;
		endcase
	end

endmodule

[design/tapp_err.sv]
module tapp_err #(
	parameter int INTEGRAL_WIDTH = tapp_pkg::INTEGRAL_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input tapp_pkg::pose_t pose,
	output tapp_pkg::lane_op_t [tapp_pkg::AXIS_COUNT-1:0] ops,
	output logic start
);

	localparam logic signed [INTEGRAL_WIDTH-1:0] SUM_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
	localparam logic signed [INTEGRAL_WIDTH-1:0] SUM_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

	logic signed [31:0] prev_x_q;
	logic signed [31:0] prev_y_q;
	logic [15:0] prev_h_q;
	logic signed [31:0] prev_err_q [tapp_pkg::AXIS_COUNT];
	logic signed [INTEGRAL_WIDTH-1:0] sum_q [tapp_pkg::AXIS_COUNT];

	logic signed [31:0] e_next [tapp_pkg::AXIS_COUNT];
	logic signed [31:0] e_s1 [tapp_pkg::AXIS_COUNT];
	logic v_s1;
	logic v_s2;
	tapp_pkg::lane_op_t [tapp_pkg::AXIS_COUNT-1:0] ops_next;
	tapp_pkg::lane_op_t [tapp_pkg::AXIS_COUNT-1:0] ops_s2;

	logic signed [32:0] diff_x;
	logic signed [32:0] diff_y;
	logic [15:0] diff_h;
	logic [15:0] dh16;
	logic signed [32:0] d_w [tapp_pkg::AXIS_COUNT];
	logic [32:0] d_neg_w [tapp_pkg::AXIS_COUNT];
	logic signed [tapp_pkg::SUM_MAG_W-1:0] s_ext [tapp_pkg::AXIS_COUNT];
	logic signed [INTEGRAL_WIDTH:0] sum_w [tapp_pkg::AXIS_COUNT];
	logic signed [INTEGRAL_WIDTH-1:0] sum_next [tapp_pkg::AXIS_COUNT];

	assign ops = ops_s2;
	assign start = v_s2;

	// error against the previous measurement
	always_comb begin
		diff_x = 33'(pose.target_x) - 33'(prev_x_q);
		diff_y = 33'(pose.target_y) - 33'(prev_y_q);
		diff_h = pose.target_heading - prev_h_q;
		e_next[tapp_pkg::AXIS_X] = tapp_pkg::sat32(diff_x);
		e_next[tapp_pkg::AXIS_Y] = tapp_pkg::sat32(diff_y);
		e_next[tapp_pkg::AXIS_HEADING] = 32'(signed'(diff_h));
	end

	always_comb begin
		dh16 = e_s1[tapp_pkg::AXIS_HEADING][15:0] - prev_err_q[tapp_pkg::AXIS_HEADING][15:0];
		for (int i = 0; i < tapp_pkg::AXIS_COUNT; i++) begin
			if (i == tapp_pkg::AXIS_HEADING) begin
				d_w[i] = 33'(signed'(dh16));
			end else begin
				d_w[i] = 33'(e_s1[i]) - 33'(prev_err_q[i]);
			end
			d_neg_w[i] = 33'd0 - d_w[i];
			s_ext[i] = tapp_pkg::SUM_MAG_W'(sum_q[i]);

			ops_next[i].e_neg = e_s1[i][31];
			ops_next[i].e_mag = e_s1[i][31] ? 32'd0 - e_s1[i] : e_s1[i];
			ops_next[i].s_neg = s_ext[i][tapp_pkg::SUM_MAG_W-1];
			ops_next[i].s_mag = s_ext[i][tapp_pkg::SUM_MAG_W-1] ?
				tapp_pkg::SUM_MAG_W'(0) - s_ext[i] : s_ext[i];
			ops_next[i].d_neg = d_w[i][32];
			ops_next[i].d_mag = d_w[i][32] ? d_neg_w[i][31:0] : d_w[i][31:0];

			sum_w[i] = (INTEGRAL_WIDTH+1)'(sum_q[i]) + (INTEGRAL_WIDTH+1)'(e_s1[i]);
			if (sum_w[i][INTEGRAL_WIDTH] != sum_w[i][INTEGRAL_WIDTH-1]) begin
				sum_next[i] = sum_w[i][INTEGRAL_WIDTH] ? SUM_MIN : SUM_MAX;
			end else begin
				sum_next[i] = sum_w[i][INTEGRAL_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < tapp_pkg::AXIS_COUNT; i++) begin
				prev_err_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			if (go) begin
				prev_x_q <= pose.meas_x;
				prev_y_q <= pose.meas_y;
				prev_h_q <= pose.meas_heading;
			end
			if (v_s1) begin
				for (int i = 0; i < tapp_pkg::AXIS_COUNT; i++) begin
					prev_err_q[i] <= e_s1[i];
					sum_q[i] <= sum_next[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < tapp_pkg::AXIS_COUNT; i++) begin
				e_s1[i] <= e_next[i];
			end
		end
		if (v_s1) begin
			ops_s2 <= ops_next;
		end
	end

endmodule

[design/tapp_lane.sv]
module tapp_lane #(
	parameter logic [31:0] FACTOR = 32'd1,
	parameter int SHIFT = 40
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic take,
	input tapp_pkg::lane_op_t op,
	input logic [31:0] kp,
	input logic [31:0] ki,
	input logic [31:0] kd,
	input logic [31:0] scale,
	input logic [30:0] limit,
	output logic done,
	output logic signed [31:0] result
);

	localparam int ACC_W = tapp_pkg::ACC_W;
	localparam int Q_W = ACC_W - SHIFT;
	localparam int SAT_BIT = SHIFT + 32;
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);

	localparam logic [3:0] ST_E = 4'd0;
	localparam logic [3:0] ST_S_LO = 4'd1;
	localparam logic [3:0] ST_S_HI = 4'd2;
	localparam logic [3:0] ST_D = 4'd3;
	localparam logic [3:0] ST_ABS = 4'd4;
	localparam logic [3:0] ST_F0 = 4'd5;
	localparam logic [3:0] ST_F1 = 4'd6;
	localparam logic [3:0] ST_F2 = 4'd7;
	localparam logic [3:0] ST_F3 = 4'd8;
	localparam logic [3:0] ST_M0 = 4'd9;
	localparam logic [3:0] ST_M1 = 4'd10;
	localparam logic [3:0] ST_M2 = 4'd11;
	localparam logic [3:0] ST_RND = 4'd12;
	localparam logic [3:0] ST_OUT = 4'd13;

	logic [3:0] step_q;
	logic run_q;
	logic done_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] mag_q;
	logic neg_q;
	logic signed [31:0] result_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [1:0] chunk;
	logic sub;
	logic [63:0] prod;
	logic [ACC_W-1:0] term;
	logic [ACC_W-1:0] base;
	logic [ACC_W-1:0] acc_next;

	logic sat;
	logic [Q_W-1:0] q;
	logic [30:0] m;
	logic signed [31:0] res;

	assign done = done_q;
	assign result = result_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		chunk = '0;
		sub = 1'b0;
		case (step_q)
			ST_E: begin
				mul_a = op.e_mag;
				mul_b = kp;
				sub = op.e_neg;
			end
			ST_S_LO: begin
				mul_a = op.s_mag[31:0];
				mul_b = ki;
				sub = op.s_neg;
			end
			ST_S_HI: begin
				mul_a = op.s_mag[tapp_pkg::SUM_MAG_W-1:32];
				mul_b = ki;
				chunk = 2'd1;
				sub = op.s_neg;
			end
			ST_D: begin
				mul_a = op.d_mag;
				mul_b = kd;
				sub = op.d_neg;
			end
			ST_F0, ST_F1, ST_F2, ST_F3: begin
				chunk = 2'(step_q - ST_F0);
				mul_a = acc_q[32*chunk +: 32];
				mul_b = FACTOR;
			end
			ST_M0, ST_M1, ST_M2: begin
				chunk = 2'(step_q - ST_M0);
				mul_a = mag_q[32*chunk +: 32];
				mul_b = scale;
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;
	assign term = ACC_W'(prod) << {chunk, 5'b0};
	assign base = (step_q == ST_E || step_q == ST_M0) ? '0 : acc_q;
	assign acc_next = sub ? base - term : base + term;

	// clamp and sign the rounded quotient
	always_comb begin
		sat = |mag_q[ACC_W-1:SAT_BIT];
		q = acc_q[ACC_W-1:SHIFT];
		if (sat) begin
			m = (scale == '0) ? '0 : limit;
		end else if (q > Q_W'(limit)) begin
			m = limit;
		end else begin
			m = q[30:0];
		end
		res = neg_q ? 32'd0 - {1'b0, m} : {1'b0, m};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_E;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				step_q <= ST_E;
				run_q <= 1'b1;
			end else if (run_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == ST_OUT) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			case (step_q)
				ST_E, ST_S_LO, ST_S_HI, ST_D, ST_M0, ST_M1, ST_M2: acc_q <= acc_next;
				ST_ABS: begin
					neg_q <= acc_q[ACC_W-1];
					acc_q <= acc_q[ACC_W-1] ? ACC_W'(0) - acc_q : acc_q;
				end
				ST_F0: mag_q <= term;
				ST_F1, ST_F2, ST_F3: mag_q <= mag_q + term;
				ST_RND: acc_q <= acc_q + HALF;
				ST_OUT: result_q <= res;
				default: ;
			endcase
		end
	end

endmodule

[design/three_axis_pid_positioner.sv]
// a result shows on out_valid after all three lanes are done and the output register can load it
// a new request is accepted only after the previous result is loaded into the output register;
// each axis lane runs a 14-step sequence on its own 32x32 multiplier
// the output register holds a result while the next request is taken
// reset: arst_n clears the pose history, error sums and control, and loads register defaults
module three_axis_pid_positioner #(
	parameter int INTEGRAL_WIDTH = tapp_pkg::INTEGRAL_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tapp_pkg::pose_t in_pose,
	output logic out_valid,
	input logic out_stall,
	output tapp_pkg::force_t out_force,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tapp_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	tapp_pkg::cfg_t cfg;
	tapp_pkg::lane_op_t [tapp_pkg::AXIS_COUNT-1:0] ops;
	logic start;
	logic accept;
	logic busy_q;
	logic load;
	logic out_valid_q;
	tapp_pkg::force_t out_q;

	logic [31:0] scale [tapp_pkg::AXIS_COUNT];
	logic [30:0] limit [tapp_pkg::AXIS_COUNT];
	logic [tapp_pkg::AXIS_COUNT-1:0] lane_done;
	logic signed [31:0] lane_res [tapp_pkg::AXIS_COUNT];

	tapp_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign accept = in_valid & ~busy_q;
	assign in_stall = busy_q;

	tapp_err #(
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_err (
		.clk(clk),
		.arst_n(arst_n),
		.go(accept),
		.pose(in_pose),
		.ops(ops),
		.start(start)
	);

	always_comb begin
		scale[tapp_pkg::AXIS_X] = cfg.mass_surge;
		scale[tapp_pkg::AXIS_Y] = cfg.mass_sway;
		scale[tapp_pkg::AXIS_HEADING] = cfg.inertia_yaw;
		limit[tapp_pkg::AXIS_X] = cfg.force_limit;
		limit[tapp_pkg::AXIS_Y] = cfg.force_limit;
		limit[tapp_pkg::AXIS_HEADING] = cfg.moment_limit;
	end

	for (genvar i = 0; i < tapp_pkg::AXIS_COUNT; i++) begin : g_lane
		tapp_lane #(
			.FACTOR(tapp_pkg::AXIS_FACTOR[i]),
			.SHIFT(tapp_pkg::AXIS_SHIFT[i])
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.start(start),
			.take(load),
			.op(ops[i]),
			.kp(cfg.kp_gain),
			.ki(cfg.ki_gain),
			.kd(cfg.kd_gain),
			.scale(scale[i]),
			.limit(limit[i]),
			.done(lane_done[i]),
			.result(lane_res[i])
		);
	end

	// merge the lanes into the output register
	assign load = (&lane_done) & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign out_force = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.force_surge <= lane_res[tapp_pkg::AXIS_X];
			out_q.force_sway <= lane_res[tapp_pkg::AXIS_Y];
			out_q.moment_yaw <= lane_res[tapp_pkg::AXIS_HEADING];
		end
	end

endmodule
